/* rtl/core/dual_button_press_timer_assert.svh */
// Assertion macros for the dual button press timer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DUAL_BUTTON_PRESS_TIMER_ASSERT_SVH
`define DUAL_BUTTON_PRESS_TIMER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DBPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dbpt assertion failed");

// Next-cycle implication, disabled while in reset.
`define DBPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dbpt assertion failed");

`endif

/* rtl/core/dbpt_pkg.sv */
// Package for the dual button press timer: payload structs, codes and widths.
// Used by dual_button_press_timer and its test bench; no dependencies.
package dbpt_pkg;

  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned OUT_TIME_BITS = 16;
  localparam int unsigned TICK_BITS = 8;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 8;

  localparam logic [TICK_BITS-1:0] TICK_INTERVAL_RST = TICK_BITS'(10);

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_PRIMARY = 2'd1,
    MODE_MIRROR  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TICK_INTERVAL   = 2'd0,
    CFG_PRIMARY_LEVEL   = 2'd1,
    CFG_MIRROR_LEVEL    = 2'd2,
    CFG_MIRROR_PRESENT  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] mode;
    logic       primary_level;
    logic       mirror_level;
  } in_t;

  typedef struct packed {
    logic [1:0]               primary_event;
    logic [1:0]               mirror_event;
    logic                     primary_held;
    logic                     mirror_held;
    logic [OUT_TIME_BITS-1:0] primary_time;
    logic [OUT_TIME_BITS-1:0] mirror_time;
    logic                     pressed_any;
    logic [OUT_TIME_BITS-1:0] pressed_time_max;
  } out_t;

endpackage

/* rtl/core/dual_button_press_timer.sv */
// Dual button press timer: edge/tick state machine with a registered result beat.
// Depends on dbpt_pkg and dual_button_press_timer_assert.svh.
`include "dual_button_press_timer_assert.svh"

// Takes one input beat per clock and returns exactly one result beat for each, in the
// cycle after acceptance. The button and prescaler state is updated in the accept
// cycle by a single pass of logic (one 17-bit saturating add per button), and the
// result is held in one output register; in_ready_o stays high while that register
// is empty or being drained, so full rate is kept as long as out_ready_i is high.
// Configuration writes take effect on the clock edge that has cfg_we_i high.
module dual_button_press_timer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dbpt_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [dbpt_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dbpt_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dbpt_pkg::out_t                      out_data_o
);
  import dbpt_pkg::*;

  // configuration
  logic [TICK_BITS-1:0] tick_interval_q;
  logic                 primary_level_cfg_q;
  logic                 mirror_level_cfg_q;
  logic                 mirror_present_q;

  // button / prescaler state
  logic                 timer_on_q, timer_on_d;
  logic [TICK_BITS-1:0] countdown_q, countdown_d;
  logic                 primary_active_q, primary_active_d;
  logic                 mirror_active_q, mirror_active_d;
  logic [TIME_BITS-1:0] primary_count_q, primary_count_d;
  logic [TIME_BITS-1:0] mirror_count_q, mirror_count_d;
  logic                 primary_armed_q, primary_armed_d;
  logic                 mirror_armed_q, mirror_armed_d;

  logic                 out_valid_q;
  out_t                 out_q, out_d;

  logic                 fire;
  event_e               pev, mev;
  logic [TIME_BITS-1:0] tmax;

  // Time after one sample while held; the first sample of a press adds twice.
  function automatic logic [TIME_BITS-1:0] grow(logic [TIME_BITS-1:0] cnt,
                                                logic [TICK_BITS-1:0] ti);
    logic [TIME_BITS:0] inc;
    logic [TIME_BITS:0] sum;
    inc = (cnt == '0) ? ((TIME_BITS+1)'(ti) << 1) : (TIME_BITS+1)'(ti);
    sum = {1'b0, cnt} + inc;
    return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  endfunction

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    timer_on_d       = timer_on_q;
    countdown_d      = countdown_q;
    primary_active_d = primary_active_q;
    mirror_active_d  = mirror_active_q;
    primary_count_d  = primary_count_q;
    mirror_count_d   = mirror_count_q;
    primary_armed_d  = primary_armed_q;
    mirror_armed_d   = mirror_armed_q;
    pev              = EV_NONE;
    mev              = EV_NONE;

    if (fire) begin
      unique case (mode_e'(in_data_i.mode))
        MODE_PRIMARY: begin
          if (primary_armed_q) begin
            primary_count_d  = '0;
            primary_active_d = 1'b1;
            primary_armed_d  = 1'b0;
            if (!timer_on_q) begin
              timer_on_d  = 1'b1;
              countdown_d = tick_interval_q;
            end
          end
        end
        MODE_MIRROR: begin
          if (mirror_present_q && mirror_armed_q) begin
            mirror_count_d  = '0;
            mirror_active_d = 1'b1;
            mirror_armed_d  = 1'b0;
            if (!timer_on_q) begin
              timer_on_d  = 1'b1;
              countdown_d = tick_interval_q;
            end
          end
        end
        MODE_TICK: begin
          if (timer_on_q && countdown_q != '0) begin
            countdown_d = countdown_q - TICK_BITS'(1);
            if (countdown_q == TICK_BITS'(1)) begin
              countdown_d = tick_interval_q;
              if (primary_active_q) begin
                if (in_data_i.primary_level == primary_level_cfg_q) begin
                  primary_count_d = grow(primary_count_q, tick_interval_q);
                  if (primary_count_q == '0) pev = EV_PRESS;
                end else begin
                  primary_active_d = 1'b0;
                  primary_count_d  = '0;
                  primary_armed_d  = 1'b1;
                  pev              = EV_RELEASE;
                end
              end
              if (mirror_present_q && mirror_active_q) begin
                if (in_data_i.mirror_level == mirror_level_cfg_q) begin
                  mirror_count_d = grow(mirror_count_q, tick_interval_q);
                  if (mirror_count_q == '0) mev = EV_PRESS;
                end else begin
                  mirror_active_d = 1'b0;
                  mirror_count_d  = '0;
                  mirror_armed_d  = 1'b1;
                  mev             = EV_RELEASE;
                end
              end
              // stop the prescaler once a release leaves nothing active
              if ((pev == EV_RELEASE || mev == EV_RELEASE) &&
                  !primary_active_d && !mirror_active_d) begin
                timer_on_d  = 1'b0;
                countdown_d = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end

    tmax = primary_count_d;
    if (mirror_present_q && mirror_count_d > primary_count_d) tmax = mirror_count_d;

    out_d.primary_event    = pev;
    out_d.mirror_event     = mev;
    out_d.primary_held     = primary_active_d;
    out_d.mirror_held      = mirror_active_d;
    out_d.primary_time     = OUT_TIME_BITS'(primary_count_d);
    out_d.mirror_time      = OUT_TIME_BITS'(mirror_count_d);
    out_d.pressed_any      = primary_active_d || (mirror_present_q && mirror_active_d);
    out_d.pressed_time_max = OUT_TIME_BITS'(tmax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_interval_q     <= TICK_INTERVAL_RST;
      primary_level_cfg_q <= 1'b0;
      mirror_level_cfg_q  <= 1'b0;
      mirror_present_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TICK_INTERVAL:  tick_interval_q     <= cfg_data_i[TICK_BITS-1:0];
        CFG_PRIMARY_LEVEL:  primary_level_cfg_q <= cfg_data_i[0];
        CFG_MIRROR_LEVEL:   mirror_level_cfg_q  <= cfg_data_i[0];
        CFG_MIRROR_PRESENT: mirror_present_q    <= cfg_data_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_on_q       <= 1'b0;
      countdown_q      <= '0;
      primary_active_q <= 1'b0;
      mirror_active_q  <= 1'b0;
      primary_count_q  <= '0;
      mirror_count_q   <= '0;
      primary_armed_q  <= 1'b1;
      mirror_armed_q   <= 1'b1;
      out_valid_q      <= 1'b0;
    end else begin
      timer_on_q       <= timer_on_d;
      countdown_q      <= countdown_d;
      primary_active_q <= primary_active_d;
      mirror_active_q  <= mirror_active_d;
      primary_count_q  <= primary_count_d;
      mirror_count_q   <= mirror_count_d;
      primary_armed_q  <= primary_armed_d;
      mirror_armed_q   <= mirror_armed_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DBPT_ASSERT_IMP(a_idle_countdown_zero, clk_i, rst_ni, !timer_on_q, countdown_q == '0)
  `DBPT_ASSERT_IMP(a_primary_arm_xor, clk_i, rst_ni, 1'b1, primary_active_q != primary_armed_q)
  `DBPT_ASSERT_IMP(a_active_needs_timer, clk_i, rst_ni, primary_active_q || mirror_active_q, timer_on_q)
  `DBPT_ASSERT_IMP(a_idle_time_zero, clk_i, rst_ni, !primary_active_q, primary_count_q == '0)
  `DBPT_ASSERT_IMP(a_release_not_held, clk_i, rst_ni, out_valid_q && out_q.primary_event == EV_RELEASE, !out_q.primary_held)

endmodule

/* verif/dual_button_press_timer_test.sv */
// Self-checking bench for dual_button_press_timer: directed and random edge/tick beats,
// each checked against an in-bench model of the buttons and the tick prescaler.
// Depends on dbpt_pkg and the dual_button_press_timer RTL.
module dual_button_press_timer_test;
  import dbpt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned MAX_PRINTS = 200;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  in_t                      in_data_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  out_t                     out_data_o;

  // bench copy of the registers
  logic [TICK_BITS-1:0] interval_reg = TICK_INTERVAL_RST;
  logic                 pri_level_reg = 1'b0;
  logic                 mir_level_reg = 1'b0;
  logic                 mir_fitted_reg = 1'b0;

  // bench copy of the button and prescaler state
  logic                 prescaler_run = 1'b0;
  logic [TICK_BITS-1:0] prescaler_cnt = '0;
  logic                 pri_busy = 1'b0;
  logic                 mir_busy = 1'b0;
  logic [TIME_BITS-1:0] pri_time = '0;
  logic [TIME_BITS-1:0] mir_time = '0;
  logic                 pri_rearmed = 1'b1;
  logic                 mir_rearmed = 1'b1;

  in_t         pending_items[$];
  out_t        expected_beats[$];
  int unsigned n_sent = 0;
  int unsigned n_taken = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  logic        calm = 1'b0;

  dual_button_press_timer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [TIME_BITS-1:0] time_add(input logic [TIME_BITS-1:0] t,
                                                    input logic [TICK_BITS-1:0] d);
    logic [TIME_BITS:0] s;
    s = {1'b0, t} + d;
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  task automatic start_prescaler();
    if (!prescaler_run) begin
      prescaler_run = 1'b1;
      prescaler_cnt = interval_reg;
    end
  endtask

  task automatic sample_button(inout logic busy, inout logic [TIME_BITS-1:0] held,
                               inout logic rearm, input logic down, output event_e ev);
    ev = EV_NONE;
    if (busy) begin
      if (down) begin
        // first sample of a press counts double
        if (held == '0) begin
          held = time_add(held, interval_reg);
          ev = EV_PRESS;
        end
        held = time_add(held, interval_reg);
      end else begin
        busy = 1'b0;
        held = '0;
        rearm = 1'b1;
        ev = EV_RELEASE;
      end
    end
  endtask

  task automatic predict_beat(input in_t beat);
    event_e pev;
    event_e mev;
    out_t   r;
    pev = EV_NONE;
    mev = EV_NONE;
    case (beat.mode)
      MODE_PRIMARY: begin
        if (pri_rearmed) begin
          pri_time = '0;
          pri_busy = 1'b1;
          pri_rearmed = 1'b0;
          start_prescaler();
        end
      end
      MODE_MIRROR: begin
        if (mir_fitted_reg && mir_rearmed) begin
          mir_time = '0;
          mir_busy = 1'b1;
          mir_rearmed = 1'b0;
          start_prescaler();
        end
      end
      MODE_TICK: begin
        // a running prescaler stuck at zero ignores ticks
        if (prescaler_run && prescaler_cnt != '0) begin
          prescaler_cnt = prescaler_cnt - 1'b1;
          if (prescaler_cnt == '0) begin
            prescaler_cnt = interval_reg;
            sample_button(pri_busy, pri_time, pri_rearmed,
                          beat.primary_level == pri_level_reg, pev);
            if (mir_fitted_reg)
              sample_button(mir_busy, mir_time, mir_rearmed,
                            beat.mirror_level == mir_level_reg, mev);
            // stop looks at the mirror even when it is not fitted
            if ((pev == EV_RELEASE || mev == EV_RELEASE) && !pri_busy && !mir_busy) begin
              prescaler_run = 1'b0;
              prescaler_cnt = '0;
            end
          end
        end
      end
      default: ;
    endcase
    r.primary_event = pev;
    r.mirror_event = mev;
    r.primary_held = pri_busy;
    r.mirror_held = mir_busy;
    r.primary_time = pri_time;
    r.mirror_time = mir_time;
    r.pressed_any = pri_busy || (mir_fitted_reg && mir_busy);
    r.pressed_time_max = (mir_fitted_reg && mir_time > pri_time) ? mir_time : pri_time;
    expected_beats.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (n_errors < MAX_PRINTS)
      $display("ERROR result %0d: %s got 0x%0h want 0x%0h", n_results, what, got, want);
    n_errors++;
  endtask

  task automatic check_beat(input out_t got, input out_t want);
    if (got.primary_event !== want.primary_event)
      report_mismatch("primary_event", got.primary_event, want.primary_event);
    if (got.mirror_event !== want.mirror_event)
      report_mismatch("mirror_event", got.mirror_event, want.mirror_event);
    if (got.primary_held !== want.primary_held)
      report_mismatch("primary_held", got.primary_held, want.primary_held);
    if (got.mirror_held !== want.mirror_held)
      report_mismatch("mirror_held", got.mirror_held, want.mirror_held);
    if (got.primary_time !== want.primary_time)
      report_mismatch("primary_time", got.primary_time, want.primary_time);
    if (got.mirror_time !== want.mirror_time)
      report_mismatch("mirror_time", got.mirror_time, want.mirror_time);
    if (got.pressed_any !== want.pressed_any)
      report_mismatch("pressed_any", got.pressed_any, want.pressed_any);
    if (got.pressed_time_max !== want.pressed_time_max)
      report_mismatch("pressed_time_max", got.pressed_time_max, want.pressed_time_max);
  endtask

  // driver: one input beat per handshake, predicted at acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_beat(in_data_i);
        n_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: result beats against the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_beats.size() == 0)
          report_mismatch("result with nothing expected", 64'(out_data_o), 64'd0);
        else
          check_beat(out_data_o, expected_beats.pop_front());
      end
      out_ready_i <= calm || ($urandom_range(99) >= 24);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_item(input logic [1:0] code, input logic plev, input logic mlev);
    in_t it;
    it.mode = code;
    it.primary_level = plev;
    it.mirror_level = mlev;
    pending_items.push_back(it);
    n_sent++;
  endtask

  task automatic wait_idle();
    while (n_taken != n_sent || expected_beats.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_TICK_INTERVAL:  interval_reg = val;
      CFG_PRIMARY_LEVEL:  pri_level_reg = val[0];
      CFG_MIRROR_LEVEL:   mir_level_reg = val[0];
      CFG_MIRROR_PRESENT: mir_fitted_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_DATA_BITS-1:0] ival, input logic plev,
                               input logic mlev, input logic fitted);
    wait_idle();
    write_reg(CFG_TICK_INTERVAL, ival);
    write_reg(CFG_PRIMARY_LEVEL, {7'd0, plev});
    write_reg(CFG_MIRROR_LEVEL, {7'd0, mlev});
    write_reg(CFG_MIRROR_PRESENT, {7'd0, fitted});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly press/hold/release sequences with random hold lengths, some noise.
  task automatic queue_presses(input int unsigned n);
    int unsigned first, span, hold_p, hold_m, total, t, k;
    logic        pd, md;
    first = n_sent;
    while (n_sent - first < n) begin
      if ($urandom_range(9) < 7) begin
        span = (interval_reg == '0) ? 4 : interval_reg;
        if ($urandom_range(3) != 0)
          push_item(MODE_PRIMARY, 1'($urandom_range(1)), 1'($urandom_range(1)));
        if ($urandom_range(2) != 0)
          push_item(MODE_MIRROR, 1'($urandom_range(1)), 1'($urandom_range(1)));
        hold_p = $urandom_range(3) * span + $urandom_range(span);
        hold_m = $urandom_range(3) * span + $urandom_range(span);
        total = ((hold_p > hold_m) ? hold_p : hold_m) + span + 1;
        for (t = 0; t < total; t++) begin
          pd = (t < hold_p) ? pri_level_reg : ~pri_level_reg;
          md = (t < hold_m) ? mir_level_reg : ~mir_level_reg;
          if ($urandom_range(19) == 0) pd = ~pd;
          if ($urandom_range(19) == 0) md = ~md;
          push_item(MODE_TICK, pd, md);
        end
      end else begin
        k = $urandom_range(1, 8);
        repeat (k)
          push_item(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int unsigned ph;
    logic [CFG_DATA_BITS-1:0] ival;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: mirror absent, so its edge is dropped
    push_item(MODE_UNUSED, 1'b1, 1'b1);
    push_item(MODE_MIRROR, 1'b0, 1'b0);

    apply_setting(8'd1, 1'b1, 1'b0, 1'b1);
    push_item(MODE_TICK, 1'b1, 1'b0);     // timer stopped
    push_item(MODE_PRIMARY, 1'b0, 1'b1);
    push_item(MODE_PRIMARY, 1'b1, 1'b0);  // disarmed, ignored
    push_item(MODE_MIRROR, 1'b0, 1'b0);
    push_item(MODE_TICK, 1'b1, 1'b0);     // both pressed
    push_item(MODE_TICK, 1'b1, 1'b0);
    push_item(MODE_UNUSED, 1'b0, 1'b1);
    push_item(MODE_TICK, 1'b0, 1'b0);     // primary released, mirror held
    push_item(MODE_PRIMARY, 1'b1, 1'b0);
    push_item(MODE_TICK, 1'b1, 1'b1);     // primary press, mirror release
    push_item(MODE_MIRROR, 1'b1, 1'b0);
    push_item(MODE_TICK, 1'b0, 1'b0);     // primary release, mirror press

    // mirror removed while it is still active: timer must keep running
    apply_setting(8'd1, 1'b1, 1'b0, 1'b0);
    push_item(MODE_PRIMARY, 1'b1, 1'b1);
    push_item(MODE_MIRROR, 1'b1, 1'b1);
    push_item(MODE_TICK, 1'b0, 1'b0);
    push_item(MODE_TICK, 1'b0, 1'b0);
    push_item(MODE_TICK, 1'b1, 1'b1);
    apply_setting(8'd1, 1'b1, 1'b0, 1'b1);
    push_item(MODE_TICK, 1'b0, 1'b1);     // mirror release stops the timer
    push_item(MODE_TICK, 1'b1, 1'b0);

    // both held across a few samples at the widest interval
    apply_setting(8'd255, 1'b0, 1'b1, 1'b1);
    push_item(MODE_PRIMARY, 1'b0, 1'b1);
    push_item(MODE_MIRROR, 1'b0, 1'b1);
    repeat (520) push_item(MODE_TICK, 1'b0, 1'b1);
    repeat (260) push_item(MODE_TICK, 1'b1, 1'b0);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ival = 8'd1;
        3: ival = 8'($urandom_range(20, 40));
        default: ival = 8'($urandom_range(2, 8));
      endcase
      apply_setting(ival, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    (ph == 0) ? 1'b0 : 1'b1);
      calm = (ph == 2);
      queue_presses(130);
    end
    calm = 1'b0;

    // zero interval locks the prescaler for good, so it runs last
    apply_setting(8'd0, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
    queue_presses(60);

    wait_idle();
    repeat (5) @(posedge clk_i);
    if (n_errors == 0 && expected_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
